// ----- rtl/dqd_pkg.sv -----
// Package for the dual quadrature decoder velocity unit.
// Stream item types, register indexes, sequencer states and scale constants.
// No dependencies.
package dqd_pkg;

    // Action codes of an input transaction
    localparam logic ACT_PIN  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_LEFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_RIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_REV   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_CIRC   = 2'd3;

    // Scale factor width and values: rpm x100 = 60 * 100 * 1e6, um to mm / us to s
    localparam int unsigned K_W = 34;
    localparam logic [K_W-1:0] RPM_K     = 34'd6000000000;
    localparam logic [K_W-1:0] UM_PER_MM = 34'd1000;

    // Divisor width: counts_per_rev (16) times elapsed_us (20)
    localparam int unsigned DIV_W = 36;

    // Four scaled results per tick: {kind, channel}
    localparam logic [1:0] TASK_LAST = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic        action;
        logic [1:0]  left_pins;
        logic [1:0]  right_pins;
        logic [19:0] elapsed_us;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] left_delta;
        logic signed [31:0] right_delta;
        logic signed [31:0] left_rpm_x100;
        logic signed [31:0] right_rpm_x100;
        logic signed [31:0] left_speed_mm_s;
        logic signed [31:0] right_speed_mm_s;
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
    } t_out_item;

endpackage

// ----- rtl/dqd_stream_if.sv -----
// Valid/ready stream channel carrying one payload item per transaction.
// Payload type is a parameter; no other dependencies.
interface dqd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/dual_quadrature_decoder_velocity_unit.sv -----
// Pin sample: no result; the next transaction can be accepted the following cycle.
// Tick: four passes of one shared multiply over the K_W scale-factor bits and a restoring
//   divide over the COUNT_BITS + K_W product bits, then the result enters the output register.
// Input is blocked from tick acceptance until its result enters the output register, so a
//   result still held there only stalls the next tick.
// Reset (i_rst_n low, sync): totals, last pins, inverts, sequencer, out valid clear; cpr=circ=1.
module dual_quadrature_decoder_velocity_unit #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dqd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dqd_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    dqd_stream_if.sink                        i_in,
    dqd_stream_if.source                      o_out
);
    import dqd_pkg::*;

    // Product of |delta| and a scale factor, shifted out MSB first into the divider
    localparam int unsigned PW  = COUNT_BITS + K_W;
    localparam int unsigned BCW = $clog2(PW);
    // Magnitude compare width: at least 33 bits to hold 2^31
    localparam int unsigned MW  = (COUNT_BITS > 33) ? COUNT_BITS : 33;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic        r_inv_left;
    logic        r_inv_right;
    logic [15:0] r_cpr;
    logic [23:0] r_circ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_left  <= 1'b0;
            r_inv_right <= 1'b0;
            r_cpr       <= 16'd1;
            r_circ      <= 24'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INVERT_LEFT:  r_inv_left  <= i_cfg_data[0];
                CFG_INVERT_RIGHT: r_inv_right <= i_cfg_data[0];
                CFG_COUNTS_REV:   r_cpr       <= i_cfg_data[15:0];
                CFG_WHEEL_CIRC:   r_circ      <= i_cfg_data[23:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input handshake
    // ---------------------------------------------------------------
    t_state r_state, n_state;
    logic   in_acc;
    logic   pin_acc;
    logic   tick_acc;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign pin_acc    = in_acc && (i_in.data.action == ACT_PIN);
    assign tick_acc   = in_acc && (i_in.data.action == ACT_TICK);

    // ---------------------------------------------------------------
    // x4 quadrature decode
    // A change that is not a double-bit jump steps by one; direction is up
    // when old bit0 equals new bit1, flipped by the invert bit.
    // ---------------------------------------------------------------
    logic [1:0]            r_last [2];
    logic [COUNT_BITS-1:0] r_total [2];
    logic [COUNT_BITS-1:0] r_at_tick [2];
    logic [1:0]            pins [2];
    logic                  inv [2];
    logic [COUNT_BITS-1:0] n_total [2];

    assign pins[0] = i_in.data.left_pins;
    assign pins[1] = i_in.data.right_pins;
    assign inv[0]  = r_inv_left;
    assign inv[1]  = r_inv_right;

    always_comb begin
        logic [1:0] diff;
        logic       up;
        for (int c = 0; c < 2; c++) begin
            diff = r_last[c] ^ pins[c];
            up   = (r_last[c][0] ~^ pins[c][1]) ^ inv[c];
            if (diff == 2'b00 || diff == 2'b11) begin
                n_total[c] = r_total[c];
            end else if (up) begin
                n_total[c] = r_total[c] + COUNT_BITS'(1);
            end else begin
                n_total[c] = r_total[c] - COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                r_last[c]    <= 2'b00;
                r_total[c]   <= '0;
                r_at_tick[c] <= '0;
            end
        end else if (pin_acc) begin
            for (int c = 0; c < 2; c++) begin
                r_last[c]  <= pins[c];
                r_total[c] <= n_total[c];
            end
        end else if (tick_acc) begin
            for (int c = 0; c < 2; c++) begin
                r_at_tick[c] <= r_total[c];
            end
        end
    end

    // ---------------------------------------------------------------
    // Tick capture: sign/magnitude of the window delta, saturated delta,
    // count snapshot and divisor counts_per_rev * elapsed_us.
    // ---------------------------------------------------------------
    logic [COUNT_BITS-1:0] raw [2];
    logic [COUNT_BITS-1:0] mag [2];
    logic                  neg [2];
    logic [31:0]           delta_sat [2];

    always_comb begin
        logic [MW-1:0] mag_ext;
        for (int c = 0; c < 2; c++) begin
            raw[c]  = r_total[c] - r_at_tick[c];
            neg[c]  = raw[c][COUNT_BITS-1];
            mag[c]  = neg[c] ? (COUNT_BITS'(0) - raw[c]) : raw[c];
            mag_ext = MW'(mag[c]);
            if (neg[c]) begin
                delta_sat[c] = (mag_ext > MW'(64'h8000_0000)) ? 32'h8000_0000
                                                               : (32'd0 - 32'(mag_ext));
            end else begin
                delta_sat[c] = (mag_ext > MW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                               : 32'(mag_ext);
            end
        end
    end

    logic [COUNT_BITS-1:0] r_mag [2];
    logic                  r_neg [2];
    logic [31:0]           r_delta [2];
    logic [31:0]           r_cnt [2];
    logic [DIV_W-1:0]      r_d;

    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            for (int c = 0; c < 2; c++) begin
                r_mag[c]   <= mag[c];
                r_neg[c]   <= neg[c];
                r_delta[c] <= delta_sat[c];
                r_cnt[c]   <= 32'($signed(r_total[c]));
            end
            r_d <= DIV_W'(r_cpr) * DIV_W'(i_in.data.elapsed_us);
        end
    end

    // ---------------------------------------------------------------
    // Shared bit-serial multiply/divide, four passes per tick.
    // Task bit0 picks the channel, bit1 picks rpm (0) or mm/s (1).
    // MUL: product accumulates one scale-factor bit per cycle, MSB first.
    // DIV: restoring divide, one product bit per cycle; quotient bits that
    //      fall off the 32-bit register set a sticky overflow.
    // ---------------------------------------------------------------
    logic [1:0]       r_task,    n_task;
    logic [BCW-1:0]   r_bit_cnt, n_bit_cnt;
    logic [PW-1:0]    r_prod,    n_prod;
    logic [K_W-1:0]   r_kreg,    n_kreg;
    logic [DIV_W-1:0] r_rem,     n_rem;
    logic [31:0]      r_quo,     n_quo;
    logic             r_ovf,     n_ovf;
    logic             res_we;
    logic             out_load;
    logic [K_W-1:0]   k_circ;
    logic [PW-1:0]    mul_add;
    logic [DIV_W:0]   rem_sh;
    logic             rem_ge;
    logic [31:0]      res_val;
    logic             res_neg;

    assign k_circ  = K_W'(r_circ) * UM_PER_MM;
    assign mul_add = r_kreg[K_W-1] ? PW'(r_mag[r_task[0]]) : '0;
    assign rem_sh  = {r_rem[DIV_W-1:0], r_prod[PW-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_d};
    assign res_neg = r_neg[r_task[0]];

    // Saturate the finished quotient to the signed 32-bit range; zero when the divisor is zero
    always_comb begin
        if (r_d == '0) begin
            res_val = 32'd0;
        end else if (res_neg) begin
            res_val = (n_ovf || n_quo > 32'h8000_0000) ? 32'h8000_0000
                                                        : (32'd0 - n_quo);
        end else begin
            res_val = (n_ovf || n_quo > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : n_quo;
        end
    end

    logic r_out_valid;

    always_comb begin
        n_state   = r_state;
        n_task    = r_task;
        n_bit_cnt = r_bit_cnt;
        n_prod    = r_prod;
        n_kreg    = r_kreg;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_ovf     = r_ovf;
        res_we    = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (tick_acc) begin
                    n_state   = ST_MUL;
                    n_task    = '0;
                    n_bit_cnt = BCW'(K_W - 1);
                    n_prod    = '0;
                    n_kreg    = RPM_K;
                end
            end
            ST_MUL: begin
                n_prod = (r_prod << 1) + mul_add;
                n_kreg = r_kreg << 1;
                if (r_bit_cnt == '0) begin
                    n_state   = ST_DIV;
                    n_bit_cnt = BCW'(PW - 1);
                    n_rem     = '0;
                    n_quo     = '0;
                    n_ovf     = 1'b0;
                end else begin
                    n_bit_cnt = r_bit_cnt - BCW'(1);
                end
            end
            ST_DIV: begin
                // remainder stays below the divisor, so it fits DIV_W bits
                n_prod = r_prod << 1;
                n_rem  = rem_ge ? DIV_W'(rem_sh - {1'b0, r_d}) : rem_sh[DIV_W-1:0];
                n_quo  = {r_quo[30:0], rem_ge};
                n_ovf  = r_ovf | r_quo[31];
                if (r_bit_cnt == '0) begin
                    res_we = 1'b1;
                    if (r_task == TASK_LAST) begin
                        n_state = ST_DONE;
                    end else begin
                        n_task    = r_task + 2'd1;
                        n_state   = ST_MUL;
                        n_bit_cnt = BCW'(K_W - 1);
                        n_prod    = '0;
                        n_kreg    = n_task[1] ? k_circ : RPM_K;
                    end
                end else begin
                    n_bit_cnt = r_bit_cnt - BCW'(1);
                end
            end
            ST_DONE: begin
                // Wait for the output register to free up
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_task  <= '0;
        end else begin
            r_state <= n_state;
            r_task  <= n_task;
        end
    end

    logic [31:0] r_scaled [4];

    always_ff @(posedge i_clk) begin
        r_bit_cnt <= n_bit_cnt;
        r_prod    <= n_prod;
        r_kreg    <= n_kreg;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_ovf     <= n_ovf;
        if (res_we) begin
            r_scaled[r_task] <= res_val;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.left_delta       <= r_delta[0];
            r_out.right_delta      <= r_delta[1];
            r_out.left_rpm_x100    <= r_scaled[0];
            r_out.right_rpm_x100   <= r_scaled[1];
            r_out.left_speed_mm_s  <= r_scaled[2];
            r_out.right_speed_mm_s <= r_scaled[3];
            r_out.left_count       <= r_cnt[0];
            r_out.right_count      <= r_cnt[1];
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

// ----- tb/sv/dual_quadrature_decoder_velocity_unit_tb.sv -----
// Self-checking testbench for the dual quadrature decoder velocity unit.
// Drives pin samples and velocity ticks, predicts each velocity report and compares.
// Depends on rtl/dqd_pkg.sv, rtl/dqd_stream_if.sv and the unit itself.
module dual_quadrature_decoder_velocity_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dqd_pkg::*;

    // A tick takes four multiply/divide passes
    localparam int TICK_LATENCY = 401;
    localparam int DRAIN_CYCLES = TICK_LATENCY + 40;
    localparam logic [63:0] RPM_X100_SCALE = 64'd6000000000;

    // Directed pin walks: each one visits all 16 (old, new) pairs starting from 00
    localparam logic [31:0] LEFT_WALK  = 32'b00_01_00_10_00_11_01_01_10_01_11_10_10_11_11_00;
    localparam logic [31:0] RIGHT_WALK = 32'b00_11_11_10_10_11_01_10_01_01_11_00_10_00_01_00;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    dqd_stream_if #(.T(t_in_item))  in_if ();
    dqd_stream_if #(.T(t_out_item)) out_if ();

    dual_quadrature_decoder_velocity_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the decoder and its registers
    // ------------------------------------------------------------------
    logic [1:0]  left_prev, right_prev;
    logic [31:0] left_total, right_total;
    logic [31:0] left_mark, right_mark;     // totals at the last tick
    logic        inv_left, inv_right;
    logic [15:0] counts_rev;
    logic [23:0] circ_um;

    t_out_item expected_reports[$];
    t_out_item got_report;
    t_out_item want_report;

    int errors;
    int pins_sent;
    int ticks_sent;
    int reports_checked;
    int settings_applied;

    // Traffic shaping knobs shared by the source and sink processes
    bit no_gaps;
    int sink_hold_cycles;
    bit dir_left, dir_right;   // preferred rotation of the random walks

    // ------------------------------------------------------------------
    // Clock, reset, timeout
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("[dual_quadrature_decoder_velocity_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    // One x4 step: no count on a repeat or a double-bit jump; up when old
    // bit0 matches new bit1, flipped by the channel's invert bit.
    function automatic logic [31:0] count_step(logic [1:0] old_pins, logic [1:0] pins,
                                               logic inv, logic [31:0] total);
        logic [1:0] diff;
        logic       up;
        diff = old_pins ^ pins;
        if (diff == 2'b00 || diff == 2'b11) return total;
        up = (old_pins[0] == pins[1]) ^ inv;
        return up ? total + 32'd1 : total - 32'd1;
    endfunction

    // Signed 32-bit saturation of a sign/magnitude pair
    function automatic logic [31:0] sat32(logic neg, logic [127:0] mag);
        logic [127:0] cap;
        cap = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (mag > cap) mag = cap;
        return neg ? 32'd0 - mag[31:0] : mag[31:0];
    endfunction

    // mag * k / d truncated toward zero and saturated to signed 32 bits, zero when the divisor is zero
    function automatic logic [31:0] rate_of(logic neg, logic [31:0] mag, logic [63:0] k,
                                            logic [35:0] d);
        logic [127:0] prod;
        if (d == 36'd0) return 32'd0;
        prod = {96'd0, mag} * {64'd0, k};
        return sat32(neg, prod / {92'd0, d});
    endfunction

    task automatic channel_velocity(input logic [31:0] total, input logic [31:0] mark,
                                    input logic [19:0] us, output logic [31:0] delta,
                                    output logic [31:0] rpm, output logic [31:0] mm_s);
        logic [31:0] raw;
        logic [31:0] mag;
        logic        neg;
        logic [35:0] d;
        raw   = total - mark;
        neg   = raw[31];
        mag   = neg ? 32'd0 - raw : raw;
        d     = {20'd0, counts_rev} * {16'd0, us};
        delta = sat32(neg, {96'd0, mag});
        rpm   = rate_of(neg, mag, RPM_X100_SCALE, d);
        mm_s  = rate_of(neg, mag, {40'd0, circ_um} * 64'd1000, d);
    endtask

    // Called at the edge where a transaction is accepted
    task automatic predict_velocity(t_in_item it);
        t_out_item rep;
        if (it.action == ACT_PIN) begin
            left_total  = count_step(left_prev, it.left_pins, inv_left, left_total);
            right_total = count_step(right_prev, it.right_pins, inv_right, right_total);
            left_prev   = it.left_pins;
            right_prev  = it.right_pins;
            pins_sent++;
        end else begin
            channel_velocity(left_total, left_mark, it.elapsed_us,
                             rep.left_delta, rep.left_rpm_x100, rep.left_speed_mm_s);
            channel_velocity(right_total, right_mark, it.elapsed_us,
                             rep.right_delta, rep.right_rpm_x100, rep.right_speed_mm_s);
            rep.left_count  = left_total;
            rep.right_count = right_total;
            left_mark  = left_total;
            right_mark = right_total;
            expected_reports.push_back(rep);
            ticks_sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, name, $signed(want), $signed(got));
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got_report = out_if.data;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected velocity report, expected none actual %h",
                         $time, got_report);
                errors++;
            end else begin
                want_report = expected_reports.pop_front();
                check_field("left_delta", want_report.left_delta, got_report.left_delta);
                check_field("right_delta", want_report.right_delta, got_report.right_delta);
                check_field("left_rpm_x100", want_report.left_rpm_x100,
                            got_report.left_rpm_x100);
                check_field("right_rpm_x100", want_report.right_rpm_x100,
                            got_report.right_rpm_x100);
                check_field("left_speed_mm_s", want_report.left_speed_mm_s,
                            got_report.left_speed_mm_s);
                check_field("right_speed_mm_s", want_report.right_speed_mm_s,
                            got_report.right_speed_mm_s);
                check_field("left_count", want_report.left_count, got_report.left_count);
                check_field("right_count", want_report.right_count, got_report.right_count);
                reports_checked++;
            end
        end
    end

    // Sink side: ready changes on the falling edge. A pending hold-off wins,
    // otherwise ready drops about 15% of cycles unless gaps are disabled.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                out_if.ready <= 1'b0;
                sink_hold_cycles--;
            end else begin
                out_if.ready <= no_gaps || ($urandom_range(99) >= 15);
            end
        end
    end

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    // Offers one transaction and returns at the edge where it is accepted;
    // valid stays high so back-to-back items need no extra cycle.
    task automatic send_item(t_in_item it);
        if (!no_gaps && $urandom_range(99) < 8) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        forever begin
            @(posedge i_clk);
            if (in_if.ready) break;
        end
        predict_velocity(it);
    endtask

    // Drop valid, let every pending report come back, then give the unit a
    // full tick latency before anything touches the registers.
    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_INVERT_LEFT:  inv_left   = data[0];
            CFG_INVERT_RIGHT: inv_right  = data[0];
            CFG_COUNTS_REV:   counts_rev = data[15:0];
            CFG_WHEEL_CIRC:   circ_um    = data;
            default: ;
        endcase
    endtask

    // Upper data bits above each register's width are junk on purpose
    task automatic apply_config(logic il, logic ir, logic [15:0] cpr, logic [23:0] circ);
        wait_idle();
        write_reg(CFG_INVERT_LEFT, {23'($urandom), il});
        write_reg(CFG_INVERT_RIGHT, {23'($urandom), ir});
        write_reg(CFG_COUNTS_REV, {8'($urandom), cpr});
        write_reg(CFG_WHEEL_CIRC, circ);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    // Next state one legal quarter step along the chosen direction
    function automatic logic [1:0] gray_step(logic [1:0] pins, logic up);
        case (pins)
            2'b00:   return up ? 2'b01 : 2'b10;
            2'b01:   return up ? 2'b11 : 2'b00;
            2'b11:   return up ? 2'b10 : 2'b01;
            default: return up ? 2'b00 : 2'b11;
        endcase
    endfunction

    // Elapsed field of a pin sample is don't-care; fill it with noise
    function automatic t_in_item pin_item(logic [1:0] l, logic [1:0] r);
        t_in_item it;
        it.action     = ACT_PIN;
        it.left_pins  = l;
        it.right_pins = r;
        it.elapsed_us = 20'($urandom);
        return it;
    endfunction

    function automatic t_in_item tick_item(logic [19:0] us);
        t_in_item it;
        it.action     = ACT_TICK;
        it.left_pins  = 2'($urandom);
        it.right_pins = 2'($urandom);
        it.elapsed_us = us;
        return it;
    endfunction

    // Mostly clean quarter steps, some holds, some noise (double jumps included)
    function automatic logic [1:0] walk_pins(logic [1:0] prev, logic up);
        int r;
        r = $urandom_range(99);
        if (r < 70) return gray_step(prev, up);
        if (r < 85) return prev;
        return 2'($urandom);
    endfunction

    function automatic t_in_item random_pin_item();
        if ($urandom_range(99) < 10) dir_left = ~dir_left;
        if ($urandom_range(99) < 10) dir_right = ~dir_right;
        return pin_item(walk_pins(left_prev, dir_left), walk_pins(right_prev, dir_right));
    endfunction

    function automatic t_in_item random_tick_item();
        case ($urandom_range(9))
            0:       return tick_item(20'd0);
            1:       return tick_item(20'd1);
            2:       return tick_item(20'hFFFFF);
            3:       return tick_item(20'($urandom));
            default: return tick_item(20'($urandom_range(1000, 50000)));
        endcase
    endfunction

    function automatic t_in_item random_item();
        if ($urandom_range(99) < 9) return random_tick_item();
        return random_pin_item();
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset defaults; every old/new pin pair on both channels, ticks at the
    // elapsed extremes (zero gives zero speeds)
    task automatic test_all_transitions();
        for (int i = 0; i < 16; i++) begin
            send_item(pin_item(LEFT_WALK[31-2*i -: 2], RIGHT_WALK[31-2*i -: 2]));
            if (i == 7) send_item(tick_item(20'd1));
        end
        send_item(tick_item(20'hFFFFF));
        send_item(pin_item(gray_step(left_prev, 1'b1), gray_step(right_prev, 1'b1)));
        send_item(tick_item(20'd0));
    endtask

    // Register extremes: zero counts per rev, positive and negative speed
    // saturation, largest divisor
    task automatic test_config_extremes();
        apply_config(1'b1, 1'b1, 16'd0, 24'hFFFFFF);
        send_item(pin_item(gray_step(left_prev, 1'b1), gray_step(right_prev, 1'b0)));
        send_item(tick_item(20'd1));
        apply_config(1'b1, 1'b1, 16'd1, 24'hFFFFFF);
        send_item(pin_item(gray_step(left_prev, 1'b1), gray_step(right_prev, 1'b0)));
        send_item(tick_item(20'd1));
        apply_config(1'b0, 1'b0, 16'hFFFF, 24'd1);
        send_item(pin_item(gray_step(left_prev, 1'b0), gray_step(right_prev, 1'b1)));
        send_item(tick_item(20'hFFFFF));
    endtask

    // Random traffic under several register settings
    task automatic test_random_phases();
        logic [15:0] cpr;
        logic [23:0] circ;
        for (int ph = 0; ph < 5; ph++) begin
            case ($urandom_range(4))
                0:       cpr = 16'd1;
                1:       cpr = 16'hFFFF;
                2:       cpr = 16'($urandom_range(1, 64));
                3:       cpr = 16'($urandom);
                default: cpr = 16'($urandom_range(100, 4096));
            endcase
            case ($urandom_range(4))
                0:       circ = 24'd1;
                1:       circ = 24'hFFFFFF;
                2:       circ = 24'd10000000;
                3:       circ = 24'($urandom);
                default: circ = 24'($urandom_range(1, 1000000));
            endcase
            // first two phases pin the small/large corners
            if (ph == 0) begin
                cpr  = 16'd1;
                circ = 24'hFFFFFF;
            end else if (ph == 1) begin
                cpr  = 16'hFFFF;
                circ = 24'd10000000;
            end
            apply_config(1'($urandom), 1'($urandom), cpr, circ);
            repeat (180) send_item(random_item());
        end
    endtask

    // Long sink hold-off with ticks every fourth transaction: the output
    // register fills, the next tick finishes behind it and input stalls
    task automatic test_backpressure();
        sink_hold_cycles = 1500;
        for (int i = 0; i < 40; i++) begin
            if (i % 4 == 3) send_item(random_tick_item());
            else            send_item(random_pin_item());
        end
    endtask

    // Back-to-back stretch with no idle cycle on either side
    task automatic test_no_idle();
        no_gaps = 1'b1;
        repeat (120) send_item(random_item());
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.data       = '0;
        no_gaps          = 1'b0;
        sink_hold_cycles = 0;
        dir_left         = 1'b1;
        dir_right        = 1'b0;
        errors           = 0;
        pins_sent        = 0;
        ticks_sent       = 0;
        reports_checked  = 0;
        settings_applied = 0;
        // reset state of the unit
        left_prev   = 2'b00;
        right_prev  = 2'b00;
        left_total  = '0;
        right_total = '0;
        left_mark   = '0;
        right_mark  = '0;
        inv_left    = 1'b0;
        inv_right   = 1'b0;
        counts_rev  = 16'd1;
        circ_um     = 24'd1;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_all_transitions();
        test_config_extremes();
        test_random_phases();
        test_backpressure();
        test_no_idle();
        wait_idle();

        $display("Run covered %0d pin samples and %0d ticks over %0d register settings,",
                 pins_sent, ticks_sent, settings_applied + 1);
        $display("with %0d velocity reports compared field by field.", reports_checked);
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("[dual_quadrature_decoder_velocity_unit] OK");
        end else begin
            $display("[dual_quadrature_decoder_velocity_unit] ERROR");
        end
        $finish;
    end

endmodule
